/* rtl/wnns_pkg.sv */
`timescale 1ns / 1ps

package wnns_pkg;

   localparam int TABLE_DEPTH_DEF   = 64;
   localparam int FEATURE_WIDTH_DEF = 32;

   localparam int NUM_LANES = 8;
   localparam int QUO_W     = 7;
   localparam int PCT_SCALE = 100;
   localparam int DIST_W    = 31;
   localparam logic [DIST_W-1:0] DIST_MAX = 31'h7FFF_FFFF;

   // lane order in the datapath and in a stored entry
   localparam int LANE_RRO   = 0;
   localparam int LANE_RRW   = 1;
   localparam int LANE_RAW   = 2;
   localparam int LANE_WP    = 3;
   localparam int LANE_WAW   = 4;
   localparam int LANE_TIME  = 5;
   localparam int LANE_RO    = 6;
   localparam int LANE_RATIO = 7;

   localparam int RO_W    = 7;
   localparam int RATIO_W = 16;
   localparam int ALG_W   = 8;
   localparam int WEIGHT_W = 3;
   localparam int COUNT_W  = 7;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 7;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT_READS    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT_WRITES   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT_TIME     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT_RO_SHARE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT_RATIO    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_RAW_DISTANCE    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_ENTRY_COUNT     = 3'd6;

   localparam logic [WEIGHT_W-1:0] RST_WEIGHT_READS    = 3'd2;
   localparam logic [WEIGHT_W-1:0] RST_WEIGHT_WRITES   = 3'd3;
   localparam logic [WEIGHT_W-1:0] RST_WEIGHT_TIME     = 3'd6;
   localparam logic [WEIGHT_W-1:0] RST_WEIGHT_RO_SHARE = 3'd6;
   localparam logic [WEIGHT_W-1:0] RST_WEIGHT_RATIO    = 3'd0;

   typedef struct packed {
      logic accept;
      logic rd_en;
      logic diff_en;
      logic scale_en;
      logic div_en;
      logic mul_en;
      logic add_en;
      logic cmp_en;
      logic out_en;
   } dp_cmd_type;

   typedef struct packed {
      logic query;
      logic empty;
      logic last_entry;
      logic div_last;
      logic rsp_free;
   } dp_status_type;

endpackage

/* rtl/wnns_ram.sv */
`timescale 1ns / 1ps

module wnns_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/wnns_ctrl.sv */
`timescale 1ns / 1ps

module wnns_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  wnns_pkg::dp_status_type status,
   output wnns_pkg::dp_cmd_type    cmd
);

   import wnns_pkg::*;

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_READ   = 9'b000000010,
      S_DIFF   = 9'b000000100,
      S_SCALE  = 9'b000001000,
      S_DIV    = 9'b000010000,
      S_MUL    = 9'b000100000,
      S_ADD    = 9'b001000000,
      S_CMP    = 9'b010000000,
      S_FINISH = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            cmd.accept = req_valid;
            if (req_valid && status.query) begin
               state_in = status.empty ? S_FINISH : S_READ;
            end
         end
         S_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = S_DIFF;
         end
         S_DIFF: begin
            cmd.diff_en = 1'b1;
            state_in    = S_SCALE;
         end
         S_SCALE: begin
            cmd.scale_en = 1'b1;
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_en = 1'b1;
            if (status.div_last) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = S_ADD;
         end
         S_ADD: begin
            cmd.add_en = 1'b1;
            state_in   = S_CMP;
         end
         S_CMP: begin
            cmd.cmp_en = 1'b1;
            state_in   = status.last_entry ? S_FINISH : S_READ;
         end
         S_FINISH: begin
            // wait until the result register is free for the next transfer
            cmd.out_en = status.rsp_free;
            if (status.rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   a_finish_only_after_cmp_or_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH && $past(state_ff) != S_FINISH) |->
         ($past(state_ff) == S_CMP || $past(state_ff) == S_IDLE))
      else $error("finish entered from a wrong state");

   a_div_left_on_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL) |-> ($past(state_ff) == S_DIV && $past(status.div_last)))
      else $error("division left early");

   a_read_follows_accept_or_cmp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |-> ($past(state_ff) == S_CMP || $past(cmd.accept)))
      else $error("table read without a query");

endmodule

/* rtl/wnns_dp.sv */
`timescale 1ns / 1ps

module wnns_dp #(
   parameter int TABLE_DEPTH   = wnns_pkg::TABLE_DEPTH_DEF,
   parameter int FEATURE_WIDTH = wnns_pkg::FEATURE_WIDTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  wnns_pkg::dp_cmd_type    cmd,
   output wnns_pkg::dp_status_type status,
   input  logic                    req_cmd,
   input  logic [5:0]              req_entry_index,
   input  logic [31:0]             req_read_ro,
   input  logic [31:0]             req_read_rw_plain,
   input  logic [31:0]             req_read_rw_after_write,
   input  logic [31:0]             req_write_plain,
   input  logic [31:0]             req_write_after_write,
   input  logic [31:0]             req_txn_time,
   input  logic [6:0]              req_ro_percent,
   input  logic [15:0]             req_txn_ratio,
   input  logic [7:0]              req_alg_id,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [7:0]              rsp_nearest_label,
   output logic [30:0]             rsp_best_distance,
   output logic                    rsp_found,
   input  logic                    csr_write_en,
   input  logic [2:0]              csr_index,
   input  logic [6:0]              csr_data
);

   import wnns_pkg::*;

   localparam int FW = FEATURE_WIDTH;
   localparam int LW = (FW > RATIO_W) ? FW : RATIO_W;
   localparam int NW = LW + QUO_W;
   localparam int SW = (LW + 6 > 32) ? LW + 6 : 32;
   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int EW = 6 * FW + RO_W + RATIO_W + ALG_W;
   localparam int OFS_RO    = 6 * FW;
   localparam int OFS_RATIO = OFS_RO + RO_W;
   localparam int OFS_ALG   = OFS_RATIO + RATIO_W;

   // configuration
   logic [WEIGHT_W-1:0] w_reads_ff, w_writes_ff, w_time_ff, w_ro_ff, w_ratio_ff;
   logic                raw_ff;
   logic [COUNT_W-1:0]  count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         w_reads_ff  <= RST_WEIGHT_READS;
         w_writes_ff <= RST_WEIGHT_WRITES;
         w_time_ff   <= RST_WEIGHT_TIME;
         w_ro_ff     <= RST_WEIGHT_RO_SHARE;
         w_ratio_ff  <= RST_WEIGHT_RATIO;
         raw_ff      <= 1'b0;
         count_ff    <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_WEIGHT_READS:    w_reads_ff  <= csr_data[WEIGHT_W-1:0];
            CSR_WEIGHT_WRITES:   w_writes_ff <= csr_data[WEIGHT_W-1:0];
            CSR_WEIGHT_TIME:     w_time_ff   <= csr_data[WEIGHT_W-1:0];
            CSR_WEIGHT_RO_SHARE: w_ro_ff     <= csr_data[WEIGHT_W-1:0];
            CSR_WEIGHT_RATIO:    w_ratio_ff  <= csr_data[WEIGHT_W-1:0];
            CSR_RAW_DISTANCE:    raw_ff      <= csr_data[0];
            CSR_ENTRY_COUNT:     count_ff    <= csr_data[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // table memory
   logic [AW+5:0] idx_wide;
   logic          wr_en;
   logic [EW-1:0] wr_data, rd_data;
   logic [CW-1:0] k_ff, n_ff, n_in;
   logic [CW+6:0] count_wide;

   assign idx_wide = (AW + 6)'(req_entry_index);
   assign wr_en    = cmd.accept && (req_cmd == CMD_LOAD)
                     && ((AW + 6)'(req_entry_index) < (AW + 6)'(TABLE_DEPTH));
   assign wr_data  = {req_alg_id, req_txn_ratio, req_ro_percent,
                      req_txn_time[FW-1:0], req_write_after_write[FW-1:0],
                      req_write_plain[FW-1:0], req_read_rw_after_write[FW-1:0],
                      req_read_rw_plain[FW-1:0], req_read_ro[FW-1:0]};

   wnns_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (idx_wide[AW-1:0]),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (k_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   assign count_wide = (CW + 7)'(count_ff);
   assign n_in = (count_wide > (CW + 7)'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH)
                                                       : count_wide[CW-1:0];

   // query and table lanes
   logic [LW-1:0] q_ff [NUM_LANES];
   logic [LW-1:0] t_lane [NUM_LANES];
   logic [LW-1:0] diff_ff [NUM_LANES];
   logic [LW-1:0] max_ff [NUM_LANES];
   logic [NW-1:0] rem_ff [NUM_LANES];
   logic [NW-1:0] dsh_ff [NUM_LANES];
   logic [QUO_W-1:0] quo_ff [NUM_LANES];
   logic [ALG_W-1:0] label_ff;
   logic [2:0] step_ff;

   always_comb begin
      for (int i = 0; i < 6; i++) begin
         t_lane[i] = LW'(rd_data[i*FW +: FW]);
      end
      t_lane[LANE_RO]    = LW'(rd_data[OFS_RO +: RO_W]);
      t_lane[LANE_RATIO] = LW'(rd_data[OFS_RATIO +: RATIO_W]);
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         q_ff[LANE_RRO]   <= LW'(req_read_ro[FW-1:0]);
         q_ff[LANE_RRW]   <= LW'(req_read_rw_plain[FW-1:0]);
         q_ff[LANE_RAW]   <= LW'(req_read_rw_after_write[FW-1:0]);
         q_ff[LANE_WP]    <= LW'(req_write_plain[FW-1:0]);
         q_ff[LANE_WAW]   <= LW'(req_write_after_write[FW-1:0]);
         q_ff[LANE_TIME]  <= LW'(req_txn_time[FW-1:0]);
         q_ff[LANE_RO]    <= LW'(req_ro_percent);
         q_ff[LANE_RATIO] <= LW'(req_txn_ratio);
      end
      if (cmd.diff_en) begin
         label_ff <= rd_data[OFS_ALG +: ALG_W];
      end
      for (int i = 0; i < NUM_LANES; i++) begin
         if (cmd.diff_en) begin
            if (q_ff[i] > t_lane[i]) begin
               diff_ff[i] <= q_ff[i] - t_lane[i];
               max_ff[i]  <= q_ff[i];
            end else begin
               diff_ff[i] <= t_lane[i] - q_ff[i];
               max_ff[i]  <= t_lane[i];
            end
         end
         if (cmd.scale_en) begin
            rem_ff[i] <= NW'(diff_ff[i]) * NW'(PCT_SCALE);
            dsh_ff[i] <= NW'(max_ff[i]) << (QUO_W - 1);
            quo_ff[i] <= '0;
         end
         if (cmd.div_en) begin
            // one restoring step per cycle, two zero operands leave a zero divisor
            if (dsh_ff[i] != '0 && rem_ff[i] >= dsh_ff[i]) begin
               rem_ff[i] <= rem_ff[i] - dsh_ff[i];
               quo_ff[i] <= {quo_ff[i][QUO_W-2:0], 1'b1};
            end else begin
               quo_ff[i] <= {quo_ff[i][QUO_W-2:0], 1'b0};
            end
            dsh_ff[i] <= dsh_ff[i] >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else if (cmd.div_en) begin
         step_ff <= status.div_last ? 3'd0 : step_ff + 3'd1;
      end
   end

   // weighting and sum
   logic [QUO_W+1:0] grp_r;
   logic [QUO_W:0]   grp_w;
   logic [LW-1:0]    grp_t, grp_o;
   logic [SW-1:0]    p_r_ff, p_w_ff, p_t_ff, p_o_ff, p_x_ff, total;
   logic [DIST_W-1:0] sum_ff;

   assign grp_r = (QUO_W + 2)'(quo_ff[LANE_RRO]) + (QUO_W + 2)'(quo_ff[LANE_RRW])
                  + (QUO_W + 2)'(quo_ff[LANE_RAW]);
   assign grp_w = (QUO_W + 1)'(quo_ff[LANE_WP]) + (QUO_W + 1)'(quo_ff[LANE_WAW]);
   assign grp_t = raw_ff ? diff_ff[LANE_TIME] : LW'(quo_ff[LANE_TIME]);
   assign grp_o = raw_ff ? diff_ff[LANE_RO]   : LW'(quo_ff[LANE_RO]);
   assign total = p_r_ff + p_w_ff + p_t_ff + p_o_ff + p_x_ff;

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         p_r_ff <= SW'(w_reads_ff)  * SW'(grp_r);
         p_w_ff <= SW'(w_writes_ff) * SW'(grp_w);
         p_t_ff <= SW'(w_time_ff)   * SW'(grp_t);
         p_o_ff <= SW'(w_ro_ff)     * SW'(grp_o);
         p_x_ff <= SW'(w_ratio_ff)  * SW'(quo_ff[LANE_RATIO]);
      end
      if (cmd.add_en) begin
         sum_ff <= (total > SW'(DIST_MAX)) ? DIST_MAX : total[DIST_W-1:0];
      end
   end

   // running best and result register
   logic [DIST_W-1:0] best_ff;
   logic [ALG_W-1:0]  win_label_ff;
   logic              found_ff;
   logic              rsp_valid_ff;
   logic [ALG_W-1:0]  rsp_alg_ff;
   logic [DIST_W-1:0] rsp_dist_ff;
   logic              rsp_found_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff     <= '0;
         n_ff     <= '0;
         best_ff  <= DIST_MAX;
         found_ff <= 1'b0;
         win_label_ff <= '0;
      end else if (cmd.accept && req_cmd == CMD_QUERY) begin
         k_ff     <= '0;
         n_ff     <= n_in;
         best_ff  <= DIST_MAX;
         found_ff <= 1'b0;
         win_label_ff <= '0;
      end else if (cmd.cmp_en) begin
         k_ff <= k_ff + CW'(1);
         if (sum_ff < best_ff) begin
            best_ff      <= sum_ff;
            win_label_ff <= label_ff;
            found_ff     <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_en) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.out_en) begin
         rsp_alg_ff   <= win_label_ff;
         rsp_dist_ff  <= best_ff;
         rsp_found_ff <= found_ff;
      end
   end

   assign status.query      = (req_cmd == CMD_QUERY);
   assign status.empty      = (n_in == '0);
   assign status.last_entry = (CW'(k_ff + CW'(1)) == n_ff);
   assign status.div_last   = (step_ff == 3'(QUO_W - 1));
   assign status.rsp_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_nearest_label = rsp_alg_ff;
   assign rsp_best_distance = rsp_dist_ff;
   assign rsp_found         = rsp_found_ff;

   a_no_winner_keeps_max: assert property (@(posedge clock) disable iff (reset)
      !found_ff |-> (best_ff == DIST_MAX && win_label_ff == '0))
      else $error("best distance moved without a winner");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      k_ff <= n_ff)
      else $error("entry counter ran past the count");

   a_quotient_bounded: assert property (@(posedge clock) disable iff (reset)
      cmd.mul_en |-> (quo_ff[LANE_RRO] <= QUO_W'(PCT_SCALE)
                      && quo_ff[LANE_WP] <= QUO_W'(PCT_SCALE)
                      && quo_ff[LANE_RATIO] <= QUO_W'(PCT_SCALE)))
      else $error("normalised distance above scale");

   a_best_never_grows: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.cmp_en) && !$past(reset) |-> best_ff <= $past(best_ff))
      else $error("running best increased");

endmodule

/* rtl/weighted_nearest_neighbor_select_top.sv */
`timescale 1ns / 1ps
// channel   direction  handshake            payload
// req_      in         req_valid/req_ready  cmd, entry_index, eight features, alg_id
// rsp_      out        rsp_valid/rsp_ready  nearest_label, best_distance, found
// csr_      in         csr_write_en         csr_index, csr_data (no read-back)
//
// a load gives no result
// a query scans n = min(entry_count, TABLE_DEPTH) table entries: each entry
// goes through a table read, difference, scaling, seven restoring steps, weighting,
// sum and compare
// one item at a time; a new item is taken once the previous result sits in the output
// register, which holds it until the transfer on rsp_
// reset is synchronous and leaves the table contents undefined; no clearing pass

module weighted_nearest_neighbor_select_top #(
   parameter int TABLE_DEPTH   = wnns_pkg::TABLE_DEPTH_DEF,
   parameter int FEATURE_WIDTH = wnns_pkg::FEATURE_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_cmd,
   input  logic [5:0]  req_entry_index,
   input  logic [31:0] req_read_ro,
   input  logic [31:0] req_read_rw_plain,
   input  logic [31:0] req_read_rw_after_write,
   input  logic [31:0] req_write_plain,
   input  logic [31:0] req_write_after_write,
   input  logic [31:0] req_txn_time,
   input  logic [6:0]  req_ro_percent,
   input  logic [15:0] req_txn_ratio,
   input  logic [7:0]  req_alg_id,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_nearest_label,
   output logic [30:0] rsp_best_distance,
   output logic        rsp_found,
   input  logic        csr_write_en,
   input  logic [2:0]  csr_index,
   input  logic [6:0]  csr_data
);

   import wnns_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   wnns_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   wnns_dp #(
      .TABLE_DEPTH   (TABLE_DEPTH),
      .FEATURE_WIDTH (FEATURE_WIDTH)
   ) u_dp (
      .clock                   (clock),
      .reset                   (reset),
      .cmd                     (cmd),
      .status                  (status),
      .req_cmd                 (req_cmd),
      .req_entry_index         (req_entry_index),
      .req_read_ro             (req_read_ro),
      .req_read_rw_plain       (req_read_rw_plain),
      .req_read_rw_after_write (req_read_rw_after_write),
      .req_write_plain         (req_write_plain),
      .req_write_after_write   (req_write_after_write),
      .req_txn_time            (req_txn_time),
      .req_ro_percent          (req_ro_percent),
      .req_txn_ratio           (req_txn_ratio),
      .req_alg_id              (req_alg_id),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_nearest_label       (rsp_nearest_label),
      .rsp_best_distance       (rsp_best_distance),
      .rsp_found               (rsp_found),
      .csr_write_en            (csr_write_en),
      .csr_index               (csr_index),
      .csr_data                (csr_data)
   );

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
   import wnns_pkg::*;

   typedef struct packed {
      logic        cmd;
      logic [5:0]  idx;
      logic [31:0] rro;
      logic [31:0] rrw;
      logic [31:0] raw;
      logic [31:0] wp;
      logic [31:0] waw;
      logic [31:0] tim;
      logic [6:0]  ro;
      logic [15:0] ratio;
      logic [7:0]  alg;
   } profile_type;

   typedef struct packed {
      logic [7:0]  alg;
      logic [30:0] distance;
      logic        found;
   } match_type;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES  = 40;
   localparam int LONG_HOLD      = 2000;
   localparam logic [2:0] CSR_UNUSED_INDEX = 3'd7;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_cmd = CMD_LOAD;
   logic [5:0]  req_entry_index = '0;
   logic [31:0] req_read_ro = '0;
   logic [31:0] req_read_rw_plain = '0;
   logic [31:0] req_read_rw_after_write = '0;
   logic [31:0] req_write_plain = '0;
   logic [31:0] req_write_after_write = '0;
   logic [31:0] req_txn_time = '0;
   logic [6:0]  req_ro_percent = '0;
   logic [15:0] req_txn_ratio = '0;
   logic [7:0]  req_alg_id = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_nearest_label;
   logic [30:0] rsp_best_distance;
   logic        rsp_found;
   logic        csr_write_en = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [6:0]  csr_data = '0;

   weighted_nearest_neighbor_select_top DUT (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predictor state, updated on transfers
   profile_type profile_tab [64];
   int unsigned w_reads = 32'(RST_WEIGHT_READS), w_writes = 32'(RST_WEIGHT_WRITES);
   int unsigned w_time = 32'(RST_WEIGHT_TIME), w_ro = 32'(RST_WEIGHT_RO_SHARE);
   int unsigned w_ratio = 32'(RST_WEIGHT_RATIO);
   logic        raw_mode = 1'b0;
   int unsigned search_count = 0;

   // stimulus planning shadow, runs ahead of the transfers
   profile_type plan_tab [64];
   bit          plan_loaded [64];

   profile_type pending_profiles [$];
   match_type   expected_matches [$];
   profile_type cur_item;
   int          drive_cnt = 0, accept_cnt = 0;
   bit          quiet = 0;
   bit          hold_req = 0;
   bit          hold_done = 0;
   int          snd_gap = 0, rcv_gap = 0, hold_cnt = 0;
   int          error_count = 0, idle_cycles = 0, items_sent = 0;

   function automatic longint unsigned abs_gap(logic [31:0] a, logic [31:0] b);
      longint unsigned la, lb;
      la = 64'(a);
      lb = 64'(b);
      return (la > lb) ? la - lb : lb - la;
   endfunction

   function automatic longint unsigned norm_gap(logic [31:0] a, logic [31:0] b);
      longint unsigned la, lb;
      la = 64'(a);
      lb = 64'(b);
      if (la == lb) return 0;
      return (100 * abs_gap(a, b)) / ((la > lb) ? la : lb);
   endfunction

   function automatic match_type nearest_match(profile_type q);
      match_type       m;
      longint unsigned best, s, t, o;
      int unsigned     n;
      m = '{alg: '0, distance: DIST_MAX, found: 1'b0};
      best = 64'(DIST_MAX);
      n = (search_count > 64) ? 64 : search_count;
      for (int k = 0; k < n; k++) begin
         if (raw_mode) begin
            t = abs_gap(profile_tab[k].tim, q.tim);
            o = abs_gap({25'd0, q.ro}, {25'd0, profile_tab[k].ro});
         end else begin
            t = norm_gap(profile_tab[k].tim, q.tim);
            o = norm_gap({25'd0, q.ro}, {25'd0, profile_tab[k].ro});
         end
         s = w_reads * (norm_gap(q.rro, profile_tab[k].rro)
                        + norm_gap(q.rrw, profile_tab[k].rrw)
                        + norm_gap(q.raw, profile_tab[k].raw))
           + w_writes * (norm_gap(q.wp, profile_tab[k].wp)
                         + norm_gap(q.waw, profile_tab[k].waw))
           + w_time * t + w_ro * o
           + w_ratio * norm_gap({16'd0, q.ratio}, {16'd0, profile_tab[k].ratio});
         if (s > 64'(DIST_MAX)) s = 64'(DIST_MAX);
         if (s < best) begin
            best = s;
            m.alg = profile_tab[k].alg;
            m.distance = s[30:0];
            m.found = 1'b1;
         end
      end
      return m;
   endfunction

   // sender
   always @(negedge clock) begin
      if (!reset && !(req_valid && accept_cnt != drive_cnt)) begin
         if (snd_gap > 0) begin
            snd_gap--;
            req_valid <= 1'b0;
         end else if (pending_profiles.size() > 0 && !quiet
                      && $urandom_range(0, 11) == 0) begin
            snd_gap = $urandom_range(1, 19) - 1;
            req_valid <= 1'b0;
         end else if (pending_profiles.size() > 0) begin
            cur_item = pending_profiles[0];
            drive_cnt++;
            req_cmd <= cur_item.cmd;
            req_entry_index <= cur_item.idx;
            req_read_ro <= cur_item.rro;
            req_read_rw_plain <= cur_item.rrw;
            req_read_rw_after_write <= cur_item.raw;
            req_write_plain <= cur_item.wp;
            req_write_after_write <= cur_item.waw;
            req_txn_time <= cur_item.tim;
            req_ro_percent <= cur_item.ro;
            req_txn_ratio <= cur_item.ratio;
            req_alg_id <= cur_item.alg;
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver
   always @(negedge clock) begin
      if (hold_cnt > 0) begin
         hold_cnt--;
         rsp_ready <= 1'b0;
      end else if (hold_req && !hold_done) begin
         hold_done = 1;
         hold_cnt = LONG_HOLD;
         rsp_ready <= 1'b0;
      end else if (rcv_gap > 0) begin
         rcv_gap--;
         rsp_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
         rcv_gap = $urandom_range(1, 19) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // monitor, predictor and watchdog
   always @(posedge clock) begin
      match_type got, want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            void'(pending_profiles.pop_front());
            accept_cnt++;
            if (cur_item.cmd == CMD_LOAD) profile_tab[cur_item.idx] = cur_item;
            else expected_matches.push_back(nearest_match(cur_item));
         end
         if (rsp_valid && rsp_ready) begin
            got = '{alg: rsp_nearest_label, distance: rsp_best_distance,
                    found: rsp_found};
            if (expected_matches.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("unexpected result alg=%0d dist=%0d found=%0b",
                           got.alg, got.distance, got.found);
            end else begin
               want = expected_matches.pop_front();
               if (got !== want) begin
                  error_count++;
                  if (error_count <= 10)
                     $display({"mismatch: expected alg=%0d dist=%0d found=%0b, ",
                               "got alg=%0d dist=%0d found=%0b"},
                              want.alg, want.distance, want.found,
                              got.alg, got.distance, got.found);
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write_en)
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   task automatic wait_idle();
      wait (pending_profiles.size() == 0 && expected_matches.size() == 0 && !req_valid);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [6:0] val);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      case (idx)
         CSR_WEIGHT_READS:    w_reads = 32'(val[2:0]);
         CSR_WEIGHT_WRITES:   w_writes = 32'(val[2:0]);
         CSR_WEIGHT_TIME:     w_time = 32'(val[2:0]);
         CSR_WEIGHT_RO_SHARE: w_ro = 32'(val[2:0]);
         CSR_WEIGHT_RATIO:    w_ratio = 32'(val[2:0]);
         CSR_RAW_DISTANCE:    raw_mode = val[0];
         CSR_ENTRY_COUNT:     search_count = 32'(val);
         default: ;
      endcase
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic setup(int wr, int ww, int wt, int wo, int wx, int rawd, int cnt);
      wait_idle();
      write_reg(CSR_WEIGHT_READS, 7'(wr));
      write_reg(CSR_WEIGHT_WRITES, 7'(ww));
      write_reg(CSR_WEIGHT_TIME, 7'(wt));
      write_reg(CSR_WEIGHT_RO_SHARE, 7'(wo));
      write_reg(CSR_WEIGHT_RATIO, 7'(wx));
      write_reg(CSR_RAW_DISTANCE, 7'(rawd));
      write_reg(CSR_ENTRY_COUNT, 7'(cnt));
   endtask

   task automatic send(profile_type p);
      if (p.cmd == CMD_LOAD) begin
         plan_tab[p.idx] = p;
         plan_loaded[p.idx] = 1;
      end
      pending_profiles.push_back(p);
      items_sent++;
   endtask

   function automatic logic [31:0] pick_feat(logic [31:0] near);
      case ($urandom_range(0, 6))
         0: return '0;
         1: return '1;
         2: return $urandom;
         3: return $urandom_range(0, 300);
         4, 5: return near;
         default: return near + $urandom_range(0, 20) - 10;
      endcase
   endfunction

   function automatic profile_type make_profile(logic cmd, logic [5:0] idx,
                                                profile_type base);
      profile_type p;
      p.cmd = cmd;
      p.idx = idx;
      p.rro = pick_feat(base.rro);
      p.rrw = pick_feat(base.rrw);
      p.raw = pick_feat(base.raw);
      p.wp = pick_feat(base.wp);
      p.waw = pick_feat(base.waw);
      p.tim = pick_feat(base.tim);
      case ($urandom_range(0, 4))
         0: p.ro = 0;
         1: p.ro = 100;
         2: p.ro = 7'($urandom_range(0, 100));
         default: p.ro = base.ro;
      endcase
      case ($urandom_range(0, 4))
         0: p.ratio = 0;
         1: p.ratio = 16'hFFFF;
         2: p.ratio = 16'($urandom);
         default: p.ratio = base.ratio;
      endcase
      p.alg = 8'($urandom);
      return p;
   endfunction

   task automatic random_phase(int nitems, int cnt, bit full_weights, bit zero_weights);
      int n, w[5];
      profile_type base;
      foreach (w[i]) w[i] = full_weights ? 7 : zero_weights ? 0 : $urandom_range(0, 7);
      setup(w[0], w[1], w[2], w[3], w[4], $urandom_range(0, 1), cnt);
      n = (cnt > 64) ? 64 : cnt;
      // queries must never reach a slot that has not been loaded
      for (int k = 0; k < n; k++)
         if (!plan_loaded[k])
            send(make_profile(CMD_LOAD, 6'(k), plan_tab[$urandom_range(0, 63)]));
      for (int i = 0; i < nitems; i++) begin
         base = plan_tab[(n > 0) ? $urandom_range(0, n - 1) : $urandom_range(0, 63)];
         if ($urandom_range(0, 99) < 40) send(make_profile(CMD_QUERY, 0, base));
         else send(make_profile(CMD_LOAD, 6'($urandom_range(0, 63)), base));
      end
   endtask

   initial begin
      profile_type p;
      int cnt;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty table query straight after reset
      p = '0;
      p.cmd = CMD_QUERY;
      send(p);
      p = '0;
      p.alg = 8'hA5;
      send(p);
      p = '{cmd: CMD_LOAD, idx: 1, rro: '1, rrw: '1, raw: '1, wp: '1, waw: '1, tim: '1,
            ro: 100, ratio: 16'hFFFF, alg: 8'h5A};
      send(p);
      p = '{cmd: CMD_LOAD, idx: 2, rro: 1000, rrw: 5, raw: 32'h8000_0000, wp: 77, waw: 0,
            tim: 12345, ro: 50, ratio: 300, alg: 8'h01};
      send(p);
      p = '0;
      p.idx = 3;
      p.alg = 8'h02;
      send(p);
      p = '{cmd: CMD_LOAD, idx: 63, rro: 32'h5555_5555, rrw: 32'hAAAA_AAAA, raw: 3,
            wp: 32'hAAAA_AAAA, waw: 32'h5555_5555, tim: 1, ro: 64, ratio: 16'hAAAA,
            alg: 8'hFF};
      send(p);
      setup(2, 3, 6, 6, 1, 0, 4);
      write_reg(CSR_UNUSED_INDEX, 7'h7F);
      // tie between slots 0 and 3, exact match, copy of slot 2, far from all
      p = '0;
      p.cmd = CMD_QUERY;
      send(p);
      p = plan_tab[1];
      p.cmd = CMD_QUERY;
      send(p);
      p = plan_tab[2];
      p.cmd = CMD_QUERY;
      send(p);
      p = '{cmd: CMD_QUERY, idx: 0, rro: '1, rrw: 0, raw: 7, wp: '1, waw: 1, tim: 0,
            ro: 100, ratio: 0, alg: 0};
      send(p);
      // raw time distance saturates on every slot for the first query, so nothing wins there
      setup(1, 1, 7, 7, 7, 1, 2);
      p = plan_tab[0];
      p.cmd = CMD_QUERY;
      p.tim = 32'h8000_0000;
      send(p);
      p.tim = 32'h0000_0005;
      p.ro = 100;
      send(p);

      random_phase(40, 64, 0, 0);
      random_phase(40, 127, 1, 0);
      random_phase(30, 0, 0, 0);
      random_phase(40, 5, 0, 1);
      random_phase(40, 3, 1, 0);
      // long stall on the result side while queries keep coming
      setup(3, 3, 3, 3, 3, 0, 2);
      hold_req = 1;
      for (int i = 0; i < 12; i++) send(make_profile(CMD_QUERY, 0, plan_tab[i % 2]));
      while (items_sent < 1100) begin
         cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 32) : $urandom_range(1, 8);
         random_phase($urandom_range(40, 80), cnt, 0, 0);
      end
      wait_idle();
      quiet = 1;
      random_phase(100, $urandom_range(1, 8), 0, 0);

      wait (pending_profiles.size() == 0 && expected_matches.size() == 0 && !req_valid);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
